@@ design/gpha_pkg.sv @@
// ----------------------------------------------------------------------------
// Gated pixel hit accumulator - shared package
// Field widths, request and result codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package gpha_pkg;

  // Default sizes of the count store
  localparam int unsigned MAX_ROWS_DEF    = 256;
  localparam int unsigned MAX_COLS_DEF    = 256;
  localparam int unsigned COUNT_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int unsigned REQ_W     = 2;
  localparam int unsigned ROW_W     = 8;
  localparam int unsigned COL_W     = 8;
  localparam int unsigned DIM_W     = 9;
  localparam int unsigned TOF_W     = 16;
  localparam int unsigned RES_W     = 32;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_W     = 16;
  // Width of the row * cols + col product before it is cut to an address
  localparam int unsigned POS_W     = 20;

  // Reset values
  localparam logic [DIM_W-1:0] DIM_RESET      = 9'd16;
  localparam logic [TOF_W-1:0] TOF_LOW_RESET  = 16'h0000;
  localparam logic [TOF_W-1:0] TOF_HIGH_RESET = 16'hFFFF;

  typedef enum logic [REQ_W-1:0] {
    REQ_PIXEL = 2'd0,
    REQ_READ  = 2'd1,
    REQ_SET   = 2'd2
  } req_e;

  typedef enum logic {
    RES_SUMMARY = 1'b0,
    RES_READ    = 1'b1
  } res_kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TOF_LOW  = 2'd0,
    CFG_TOF_HIGH = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_CLEAR,
    S_LOOKUP,
    S_UPDATE,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [DIM_W-1:0] frame_rows;
    logic [DIM_W-1:0] frame_cols;
    logic [TOF_W-1:0] tof;
    logic             last_pixel;
    logic [RES_W-1:0] new_frame_count;
  } req_item_t;

  typedef struct packed {
    logic             result_kind;
    logic [RES_W-1:0] pixel_count;
    logic [RES_W-1:0] max_count;
    logic [RES_W-1:0] frame_count;
  } res_item_t;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;     // take an item this cycle
    logic clr_write;    // write zero at the sweep pointer and advance it
    logic dim_clear;    // keep new dimensions, zero frame counter, open frame
    logic frame_open;   // mark frame as open
    logic update;       // apply read data to the store and summary state
    logic load_merged;  // load the frame counter
    logic emit;         // load the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             dims_differ;
    logic             in_frame;
    logic             clr_done;
    logic             wants_result;
    logic             out_free;
  } status_t;

endpackage

`default_nettype wire

@@ design/gpha_if.sv @@
// ----------------------------------------------------------------------------
// Gated pixel hit accumulator - channel interfaces
// Request, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface gpha_req_if;
  import gpha_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [REQ_W-1:0]     req_type;
  logic [ROW_W-1:0]     row;
  logic [COL_W-1:0]     col;
  logic [DIM_W-1:0]     frame_rows;
  logic [DIM_W-1:0]     frame_cols;
  logic [TOF_W-1:0]     tof;
  logic                 last_pixel;
  logic [RES_W-1:0]     new_frame_count;

  modport source (output valid, req_type, row, col, frame_rows, frame_cols, tof,
                  last_pixel, new_frame_count, input ready);
  modport sink   (input valid, req_type, row, col, frame_rows, frame_cols, tof,
                  last_pixel, new_frame_count, output ready);
endinterface

interface gpha_res_if;
  import gpha_pkg::*;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [RES_W-1:0] pixel_count;
  logic [RES_W-1:0] max_count;
  logic [RES_W-1:0] frame_count;

  modport source (output valid, result_kind, pixel_count, max_count, frame_count,
                  input ready);
  modport sink   (input valid, result_kind, pixel_count, max_count, frame_count,
                  output ready);
endinterface

interface gpha_cfg_if;
  import gpha_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

@@ design/gpha_ram.sv @@
// ----------------------------------------------------------------------------
// Gated pixel hit accumulator - generic single-port RAM
// One read or write address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gpha_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write, then register the read word
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ design/gpha_ctrl.sv @@
// ----------------------------------------------------------------------------
// Gated pixel hit accumulator - controller
// Sequences one item at a time: decode, store sweep, lookup, update, emit.
// ----------------------------------------------------------------------------
`default_nettype none

module gpha_ctrl
  import gpha_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    req_valid_i,
  input  wire status_t st_i,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  // State register; reset starts with a sweep of the store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_INIT: begin
        if (st_i.clr_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        case (st_i.req_type)
          REQ_PIXEL: begin
            if (!st_i.in_frame && st_i.dims_differ) begin
              state_d = S_CLEAR;
            end else begin
              state_d = S_LOOKUP;
            end
          end
          REQ_READ: state_d = S_LOOKUP;
          default:  state_d = S_IDLE;
        endcase
      end
      S_CLEAR: begin
        if (st_i.clr_done) state_d = S_LOOKUP;
      end
      S_LOOKUP: state_d = S_UPDATE;
      S_UPDATE: begin
        state_d = st_i.wants_result ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (st_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_INIT;
    endcase
  end

  // Commands; the lookup cycle only presents the item address
  always_comb begin
    cmd_o = '0;
    case (state_q)
      S_INIT:   cmd_o.clr_write = 1'b1;
      S_IDLE:   cmd_o.in_ready  = 1'b1;
      S_DECODE: begin
        case (st_i.req_type)
          REQ_PIXEL: begin
            if (!st_i.in_frame && st_i.dims_differ) begin
              cmd_o.dim_clear = 1'b1;
            end else begin
              cmd_o.frame_open = 1'b1;
            end
          end
          REQ_SET: cmd_o.load_merged = 1'b1;
          default: cmd_o = '0;
        endcase
      end
      S_CLEAR:  cmd_o.clr_write = 1'b1;
      S_UPDATE: cmd_o.update    = 1'b1;
      S_EMIT:   cmd_o.emit      = st_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

endmodule

`default_nettype wire

@@ design/gpha_dpath.sv @@
// ----------------------------------------------------------------------------
// Gated pixel hit accumulator - datapath
// Item register, window registers, count store, peak and frame counters,
// and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module gpha_dpath
  import gpha_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS    = MAX_COLS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cmd_t                 cmd_i,
  output status_t                   st_o,
  input  wire logic                 req_valid_i,
  input  wire req_item_t            req_item_i,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [CFG_W-1:0]     cfg_wdata_i,
  output logic                      res_valid_o,
  input  wire logic                 res_ready_i,
  output res_item_t                 res_item_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);

  req_item_t              item_q;
  logic [TOF_W-1:0]       tof_low_q, tof_high_q;
  logic [DIM_W-1:0]       rows_q, cols_q;
  logic                   in_frame_q;
  logic [COUNT_WIDTH-1:0] peak_q;
  logic [RES_W-1:0]       merged_q;
  logic [AddrW-1:0]       clr_ptr_q;
  logic [COUNT_WIDTH-1:0] pix_q;
  logic                   out_valid_q;
  res_item_t              out_q;

  logic                   is_pixel, is_read;
  logic                   in_store, in_frame_dims, tof_hit, hit;
  logic [AddrW-1:0]       item_addr;
  logic [COUNT_WIDTH-1:0] rd_data, cnt_inc;
  logic                   ram_we;
  logic [AddrW-1:0]       ram_addr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic                   clr_done, out_free, frame_end;

  // Decode the held item
  assign is_pixel = (item_q.req_type == REQ_PIXEL);
  assign is_read  = (item_q.req_type == REQ_READ);

  assign in_store = (32'(item_q.row) < 32'(MAX_ROWS)) && (32'(item_q.col) < 32'(MAX_COLS));
  assign in_frame_dims = ({1'b0, item_q.row} < rows_q) && ({1'b0, item_q.col} < cols_q);
  assign tof_hit = (item_q.tof != '0) && (tof_low_q <= item_q.tof) &&
                   (item_q.tof <= tof_high_q);
  assign hit = in_store && in_frame_dims && tof_hit;
  assign frame_end = cmd_i.update && is_pixel && item_q.last_pixel;

  assign item_addr = AddrW'(POS_W'(item_q.row) * POS_W'(MAX_COLS) + POS_W'(item_q.col));

  // Saturating increment of the stored count
  assign cnt_inc = (rd_data == '1) ? rd_data : rd_data + COUNT_WIDTH'(1);

  // Store port: sweep writes zero, update writes the incremented count
  assign ram_we    = cmd_i.clr_write || (cmd_i.update && is_pixel && hit);
  assign ram_addr  = cmd_i.clr_write ? clr_ptr_q : item_addr;
  assign ram_wdata = cmd_i.clr_write ? '0 : cnt_inc;

  gpha_ram #(
    .WIDTH(COUNT_WIDTH),
    .DEPTH(Depth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(rd_data)
  );

  assign clr_done = (clr_ptr_q == LastAddr);
  assign out_free = !out_valid_q || res_ready_i;

  // Status towards the controller
  always_comb begin
    st_o.req_type     = item_q.req_type;
    st_o.dims_differ  = (item_q.frame_rows != rows_q) || (item_q.frame_cols != cols_q);
    st_o.in_frame     = in_frame_q;
    st_o.clr_done     = clr_done;
    st_o.wants_result = is_read || (is_pixel && item_q.last_pixel);
    st_o.out_free     = out_free;
  end

  // Window registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tof_low_q  <= TOF_LOW_RESET;
      tof_high_q <= TOF_HIGH_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_TOF_LOW:  tof_low_q  <= cfg_wdata_i;
        CFG_TOF_HIGH: tof_high_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.dim_clear) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr_write) begin
      clr_ptr_q <= clr_done ? '0 : clr_ptr_q + AddrW'(1);
    end
  end

  // Frame state: dimensions, open flag, frame counter, peak
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= DIM_RESET;
      cols_q     <= DIM_RESET;
      in_frame_q <= 1'b0;
      merged_q   <= '0;
      peak_q     <= '0;
    end else begin
      if (cmd_i.dim_clear) begin
        rows_q <= item_q.frame_rows;
        cols_q <= item_q.frame_cols;
      end
      if (cmd_i.dim_clear || cmd_i.frame_open) begin
        in_frame_q <= 1'b1;
      end else if (frame_end) begin
        in_frame_q <= 1'b0;
      end
      if (cmd_i.dim_clear) begin
        merged_q <= '0;
      end else if (cmd_i.load_merged) begin
        merged_q <= item_q.new_frame_count;
      end else if (frame_end) begin
        merged_q <= merged_q + RES_W'(1);
      end
      if (cmd_i.update && is_pixel && hit && (cnt_inc > peak_q)) begin
        peak_q <= cnt_inc;
      end
    end
  end

  // Output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Payload registers: held item, read count, output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_ready && req_valid_i) begin
      item_q <= req_item_i;
    end
    if (cmd_i.update) begin
      pix_q <= (is_read && in_store) ? rd_data : '0;
    end
    if (cmd_i.emit) begin
      out_q.result_kind <= is_read ? RES_READ : RES_SUMMARY;
      out_q.pixel_count <= RES_W'(pix_q);
      out_q.max_count   <= RES_W'(peak_q);
      out_q.frame_count <= merged_q;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_item_o  = out_q;

endmodule

`default_nettype wire

@@ design/gated_pixel_hit_accumulator_top.sv @@
// ----------------------------------------------------------------------------
// Gated pixel hit accumulator - top level
// Builds a hit-count image from time-gated detector pixels, answers pixel
// reads and reports frame summaries.
//
//   channel  direction  handshake          carries
//   req_i    in         valid/ready        one request (pixel, read, set)
//   res_o    out        valid/ready        frame summary or pixel read
//   cfg_i    in         valid/ready (=1)   window register write
//
// One request at a time. Pixels and reads look up the single-port count
// store and a hit writes the incremented count back; a last pixel or a read
// then waits while the output register is still full. A first pixel with new
// dimensions adds a sweep that zeroes all MAX_ROWS * MAX_COLS words of the
// store (65536 by default). After reset the same sweep runs with req_i.ready
// low; cfg_i writes are taken throughout.
// ----------------------------------------------------------------------------
`default_nettype none

module gated_pixel_hit_accumulator_top
  import gpha_pkg::*;
#(
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF,
  parameter int unsigned MAX_COLS    = MAX_COLS_DEF,
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  gpha_req_if.sink  req_i,
  gpha_res_if.source res_o,
  gpha_cfg_if.sink  cfg_i
);

  cmd_t      cmd;
  status_t   st;
  req_item_t req_item;
  res_item_t res_item;
  logic      res_valid;

  // Pack the request payload
  always_comb begin
    req_item.req_type        = req_i.req_type;
    req_item.row             = req_i.row;
    req_item.col             = req_i.col;
    req_item.frame_rows      = req_i.frame_rows;
    req_item.frame_cols      = req_i.frame_cols;
    req_item.tof             = req_i.tof;
    req_item.last_pixel      = req_i.last_pixel;
    req_item.new_frame_count = req_i.new_frame_count;
  end

  assign req_i.ready = cmd.in_ready;
  assign cfg_i.ready = 1'b1;

  gpha_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_i.valid),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  gpha_dpath #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .st_o       (st),
    .req_valid_i(req_i.valid),
    .req_item_i (req_item),
    .cfg_we_i   (cfg_i.valid),
    .cfg_index_i(cfg_i.reg_index),
    .cfg_wdata_i(cfg_i.wdata),
    .res_valid_o(res_valid),
    .res_ready_i(res_o.ready),
    .res_item_o (res_item)
  );

  // Unpack the result payload
  assign res_o.valid       = res_valid;
  assign res_o.result_kind = res_item.result_kind;
  assign res_o.pixel_count = res_item.pixel_count;
  assign res_o.max_count   = res_item.max_count;
  assign res_o.frame_count = res_item.frame_count;

endmodule

`default_nettype wire

@@ design/gpha_checker.sv @@
// ----------------------------------------------------------------------------
// Gated pixel hit accumulator - port checker
// Handshake and sequencing checks on the top-level ports, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module gpha_checker
  import gpha_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             req_valid_i,
  input wire logic             req_ready_i,
  input wire logic             res_valid_i,
  input wire logic             res_ready_i,
  input wire logic             res_kind_i,
  input wire logic [RES_W-1:0] res_pixel_count_i,
  input wire logic [RES_W-1:0] res_max_count_i,
  input wire logic [RES_W-1:0] res_frame_count_i
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(res_kind_i) && $stable(res_pixel_count_i) &&
      $stable(res_max_count_i) && $stable(res_frame_count_i))
    else $error("result payload changed while stalled");

  // One request in flight: no transfer in the cycle after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while previous one still in work");

  // Frame summaries carry no pixel count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == RES_SUMMARY) |-> res_pixel_count_i == '0)
    else $error("frame summary with nonzero pixel count");

endmodule

bind gated_pixel_hit_accumulator_top gpha_checker u_gpha_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_kind_i       (res_o.result_kind),
  .res_pixel_count_i(res_o.pixel_count),
  .res_max_count_i  (res_o.max_count),
  .res_frame_count_i(res_o.frame_count)
);

`default_nettype wire
